### design/deque_with_sorting_insert_macros.svh
// Assertion macros shared by the deque checker.
`ifndef DEQUE_WITH_SORTING_INSERT_MACROS_SVH
`define DEQUE_WITH_SORTING_INSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define DWSI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on a result, checked only in the cycle that carries a result.
`define DWSI_ASSERT_ON_DONE(label, prop, msg) \
    `DWSI_ASSERT(label, done |-> (prop), msg)

`endif

### design/dwsi_pkg.sv
// Package with the request codes, status codes and cell control types of the deque.
package dwsi_pkg;

    localparam logic [2:0] KIND_PUSH_FRONT  = 3'd0;
    localparam logic [2:0] KIND_PUSH_BACK   = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT   = 3'd2;
    localparam logic [2:0] KIND_POP_BACK    = 3'd3;
    localparam logic [2:0] KIND_SORT_INSERT = 3'd4;
    localparam logic [2:0] KIND_QUERY       = 3'd5;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY_POP = 2'd1;
    localparam logic [1:0] STATUS_FULL_PUSH = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_LOAD,
        CELL_SORT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;
    } cell_ctrl_t;

endpackage

### design/dwsi_cell.sv
// One storage cell of the deque, with shift, load and compare-exchange with its neighbors.
module dwsi_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  logic                clk,
    input  dwsi_pkg::cell_ctrl_t ctrl,
    input  logic [CW-1:0]       count,
    input  logic signed [31:0]  value,
    input  logic signed [31:0]  left_data,
    input  logic signed [31:0]  right_data,
    output logic signed [31:0]  data
);

    localparam logic        PARITY   = 1'(INDEX % 2);
    localparam logic        HAS_LEFT = (INDEX > 0);
    localparam logic [CW:0] POS      = (CW+1)'(INDEX);
    localparam logic [CW:0] POS_UP   = (CW+1)'(INDEX + 1);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic               left_pair_on;
    logic               right_pair_on;

    assign left_pair_on  = (PARITY == ctrl.phase) && ({1'b0, count} > POS_UP);
    assign right_pair_on = HAS_LEFT && (PARITY != ctrl.phase) && ({1'b0, count} > POS);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            dwsi_pkg::CELL_HOLD:
            begin
                data_next = data_reg;
            end
            dwsi_pkg::CELL_SHIFT_UP:
            begin
                data_next = HAS_LEFT ? left_data : value;
            end
            dwsi_pkg::CELL_SHIFT_DOWN:
            begin
                data_next = right_data;
            end
            dwsi_pkg::CELL_LOAD:
            begin
                if (count == CW'(INDEX))
                begin
                    data_next = value;
                end
            end
            dwsi_pkg::CELL_SORT:
            begin
                if (left_pair_on && (right_data < data_reg))
                begin
                    data_next = right_data;
                end
                else if (right_pair_on && (data_reg < left_data))
                begin
                    data_next = left_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### design/deque_with_sorting_insert.sv
// Top level of the bounded double-ended queue with a sorting insert.
//
//  channel   | handshake        | payload
//  ----------+------------------+-------------------------------------------------
//  request   | start, busy      | kind, value
//  result    | done             | popped_value, popped_valid, entry_count,
//            |                  | empty_flag, status
//
// Pushes, pops and queries show their result in the next cycle, when a new request may also follow.
// A sorting insert first appends the value at the back and then runs one odd-even transposition
// phase per stored entry in the row of cells, with busy high until the last phase.
// The result shows in the cycle after the last step and cannot be held off by the receiver.
// Reset clears the entry count and the controller; the cell contents are not cleared.
module deque_with_sorting_insert #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         kind,
    input  logic signed [31:0] value,
    output logic               done,
    output logic signed [31:0] popped_value,
    output logic               popped_valid,
    output logic [4:0]         entry_count,
    output logic               empty_flag,
    output logic [1:0]         status
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_SORT
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      pass_reg, pass_next;
    logic               done_reg, done_next;
    logic signed [31:0] popped_value_reg, popped_value_next;
    logic               popped_valid_reg, popped_valid_next;
    logic [4:0]         entry_count_reg, entry_count_next;
    logic               empty_flag_reg, empty_flag_next;
    logic [1:0]         status_reg, status_next;

    dwsi_pkg::cell_ctrl_t cell_ctrl;
    logic signed [31:0]   cell_data [DEPTH];
    logic                 accept;
    logic                 full;
    logic                 empty;
    logic [CW-1:0]        count_m1;
    logic [IW-1:0]        back_idx;

    assign accept   = start && (state_reg == ST_IDLE);
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - 1'b1;
    assign back_idx = count_m1[IW-1:0];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [31:0] left_in;
        logic signed [31:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_mid_left
            assign left_in = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_right
            assign right_in = cell_data[i+1];
        end

        dwsi_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .count      (count_reg),
            .value      (value),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i])
        );
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        pass_next         = pass_reg;
        done_next         = 1'b0;
        popped_value_next = '0;
        popped_valid_next = 1'b0;
        status_next       = dwsi_pkg::STATUS_DONE;
        cell_ctrl.op      = dwsi_pkg::CELL_HOLD;
        cell_ctrl.phase   = pass_reg[0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    case (kind)
                        dwsi_pkg::KIND_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = dwsi_pkg::STATUS_FULL_PUSH;
                            end
                            else
                            begin
                                cell_ctrl.op = dwsi_pkg::CELL_SHIFT_UP;
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        dwsi_pkg::KIND_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = dwsi_pkg::STATUS_FULL_PUSH;
                            end
                            else
                            begin
                                cell_ctrl.op = dwsi_pkg::CELL_LOAD;
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        dwsi_pkg::KIND_SORT_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = dwsi_pkg::STATUS_FULL_PUSH;
                            end
                            else
                            begin
                                cell_ctrl.op = dwsi_pkg::CELL_LOAD;
                                count_next   = count_reg + 1'b1;
                                pass_next    = '0;
                                done_next    = 1'b0;
                                state_next   = ST_SORT;
                            end
                        end
                        dwsi_pkg::KIND_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = dwsi_pkg::STATUS_EMPTY_POP;
                            end
                            else
                            begin
                                popped_value_next = cell_data[0];
                                popped_valid_next = 1'b1;
                                cell_ctrl.op      = dwsi_pkg::CELL_SHIFT_DOWN;
                                count_next        = count_m1;
                            end
                        end
                        dwsi_pkg::KIND_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = dwsi_pkg::STATUS_EMPTY_POP;
                            end
                            else
                            begin
                                popped_value_next = cell_data[back_idx];
                                popped_valid_next = 1'b1;
                                count_next        = count_m1;
                            end
                        end
                        default:
                        begin
                            status_next = dwsi_pkg::STATUS_DONE;
                        end
                    endcase
                end
            end
            ST_SORT:
            begin
                cell_ctrl.op = dwsi_pkg::CELL_SORT;
                pass_next    = pass_reg + 1'b1;
                if (pass_reg == count_m1)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        entry_count_next = 5'(count_next);
        empty_flag_next  = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            pass_reg         <= '0;
            done_reg         <= 1'b0;
            popped_value_reg <= '0;
            popped_valid_reg <= 1'b0;
            entry_count_reg  <= '0;
            empty_flag_reg   <= 1'b1;
            status_reg       <= dwsi_pkg::STATUS_DONE;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            pass_reg         <= pass_next;
            done_reg         <= done_next;
            popped_value_reg <= popped_value_next;
            popped_valid_reg <= popped_valid_next;
            entry_count_reg  <= entry_count_next;
            empty_flag_reg   <= empty_flag_next;
            status_reg       <= status_next;
        end
    end

    assign busy         = (state_reg == ST_SORT);
    assign done         = done_reg;
    assign popped_value = popped_value_reg;
    assign popped_valid = popped_valid_reg;
    assign entry_count  = entry_count_reg;
    assign empty_flag   = empty_flag_reg;
    assign status       = status_reg;

endmodule

### design/dwsi_checker.sv
// Port-level checker for the deque and its bind to the top level.
`include "deque_with_sorting_insert_macros.svh"

module dwsi_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [2:0]         kind,
    input logic               done,
    input logic signed [31:0] popped_value,
    input logic               popped_valid,
    input logic [4:0]         entry_count,
    input logic               empty_flag,
    input logic [1:0]         status
);

    `DWSI_ASSERT(a_quick_result, start && !busy && (kind != dwsi_pkg::KIND_SORT_INSERT) |=> done, "request without result")
    `DWSI_ASSERT_ON_DONE(a_status_code, status != 2'd3, "undefined status code")
    `DWSI_ASSERT_ON_DONE(a_empty_count, !empty_flag || (entry_count == 5'd0), "empty with entries")
    `DWSI_ASSERT_ON_DONE(a_pop_status, !popped_valid || (status == dwsi_pkg::STATUS_DONE), "pop with bad status")
    `DWSI_ASSERT_ON_DONE(a_pop_zero, popped_valid || (popped_value == 32'sd0), "value without pop")

endmodule

bind deque_with_sorting_insert dwsi_checker u_dwsi_checker (.*);
